FILE: design/pid_controller_with_settle_core_defines.svh
// Assertion macros for the PID controller core.
// Included by pid_controller_with_settle_core, which checks its own sequencing.
`ifndef PID_CONTROLLER_WITH_SETTLE_CORE_DEFINES_SVH
`define PID_CONTROLLER_WITH_SETTLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcs assertion failed");
`define PCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcs assertion failed");
`else
`define PCS_ASSERT_IMPL(lbl, ante, cons)
`define PCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/pcs_pkg.sv
// Shared types and constants of the PID controller core.
// No dependencies.
package pcs_pkg;

    localparam int unsigned DERIV_TOLERANCE = 32768;
    localparam int unsigned SETTLE_MSEC     = 100;
    localparam int unsigned USEC_PER_SEC    = 1000000;
    localparam int unsigned MS_MAX          = 65535;

    // ceil(2^59 / 15625): x / 1e6 == ((x >> 6) * USEC_RECIP) >> 59 for x < 2^51
    localparam logic [47:0] USEC_RECIP = 48'd36893488147420;
    // ceil(2^24 / 125): t / 1000 == ((t >> 3) * MSEC_RECIP) >> 24 for t < 2^20
    localparam logic [17:0] MSEC_RECIP = 18'd134218;

    localparam logic signed [31:0] OUT_MIN_RST   = -32'sd786432;
    localparam logic signed [31:0] OUT_MAX_RST   = 32'sd786432;
    localparam logic [46:0]        INTEG_LIM_RST = 47'd65536000000;
    localparam logic [30:0]        ERR_TOL_RST   = 31'd32768;

    localparam int unsigned DIV_STEPS = 53;

    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_SETPOINT   = 3'd3,
        REG_OUT_MIN    = 3'd4,
        REG_OUT_MAX    = 3'd5,
        REG_INTEG_LIM  = 3'd6,
        REG_ERR_TOL    = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_R,
        ST_INT_UPD,
        ST_MUL_D,
        ST_DIV_D,
        ST_DERIV,
        ST_G_LOAD,
        ST_MUL_G,
        ST_GSUM,
        ST_FINISH
    } state_t;

endpackage

FILE: design/pid_controller_with_settle_core.sv
// PID controller core with integral clamp and settle detection.
// Depends on pcs_pkg and pid_controller_with_settle_core_defines.svh.
//
// Usage:
//   s_ channel beats carry a Q16.16 measurement and the elapsed time in us;
//   each accepted beat yields exactly one m_ beat with the clamped drive and
//   the settled flag. The user must write gains, setpoint, limits and
//   tolerance on the cfg_ port only while the block is idle; the block
//   itself does not enforce it. Unknown indexes do not exist. One item
//   runs through a sequencer around one shared shift-add multiplier (one
//   multiplier bit per cycle) and one restoring divider for the derivative
//   (one quotient bit per cycle). The integral divide by 1e6 is a reciprocal
//   multiply on the shared multiplier; the millisecond count is a small
//   constant multiply. The multiplies end early on leading zeros; if the
//   elapsed time is at most 1 us, the derivative is zero with no divide.
//   s_tready is high only in idle: a new item waits until the last is done.
//   Reset (aresetn low, synchronous) restores the default registers and
//   clears last error, integral and the settle counter.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver still stalls when the next result is ready,
//   the sequencer holds that result until the output register frees.
`include "pid_controller_with_settle_core_defines.svh"
module pid_controller_with_settle_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [31:0] measurement, [51:32] elapsed_us
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] drive, [32] settled
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [46:0] cfg_wdata
);

    pcs_pkg::state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  gsel_reg, gsel_next;
    logic signed [31:0] err_reg, err_next;
    logic [19:0] dt_reg, dt_next;
    logic signed [31:0] last_err_reg, last_err_next;
    logic signed [47:0] integ_reg, integ_next;
    logic [15:0] tol_ms_reg, tol_ms_next;
    logic [91:0] acc_reg, acc_next;
    logic [91:0] mcd_reg, mcd_next;
    logic [47:0] mpl_reg, mpl_next;
    logic [19:0] rem_reg, rem_next;
    logic [19:0] div_reg, div_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] deriv_reg, deriv_next;
    logic signed [65:0] dacc_reg, dacc_next;
    logic [31:0] out_drive_reg, out_drive_next;
    logic        out_set_reg, out_set_next;
    logic        m_valid_reg, m_valid_next;

    logic signed [31:0] kp_reg, ki_reg, kd_reg, sp_reg, omin_reg, omax_reg;
    logic [46:0] ilim_reg;
    logic [30:0] etol_reg;

    assign s_tready = (state_reg == pcs_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_set_reg, out_drive_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            sp_reg   <= '0;
            omin_reg <= pcs_pkg::OUT_MIN_RST;
            omax_reg <= pcs_pkg::OUT_MAX_RST;
            ilim_reg <= pcs_pkg::INTEG_LIM_RST;
            etol_reg <= pcs_pkg::ERR_TOL_RST;
        end else if (cfg_wen) begin
            unique case (pcs_pkg::reg_idx_t'(cfg_addr))
                pcs_pkg::REG_PROP_GAIN:  kp_reg   <= cfg_wdata[31:0];
                pcs_pkg::REG_INTEG_GAIN: ki_reg   <= cfg_wdata[31:0];
                pcs_pkg::REG_DERIV_GAIN: kd_reg   <= cfg_wdata[31:0];
                pcs_pkg::REG_SETPOINT:   sp_reg   <= cfg_wdata[31:0];
                pcs_pkg::REG_OUT_MIN:    omin_reg <= cfg_wdata[31:0];
                pcs_pkg::REG_OUT_MAX:    omax_reg <= cfg_wdata[31:0];
                pcs_pkg::REG_INTEG_LIM:  ilim_reg <= cfg_wdata;
                pcs_pkg::REG_ERR_TOL:    etol_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pcs_pkg::ST_IDLE;
            cnt_reg      <= '0;
            gsel_reg     <= '0;
            last_err_reg <= '0;
            integ_reg    <= '0;
            tol_ms_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            gsel_reg     <= gsel_next;
            last_err_reg <= last_err_next;
            integ_reg    <= integ_next;
            tol_ms_reg   <= tol_ms_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg       <= err_next;
        dt_reg        <= dt_next;
        acc_reg       <= acc_next;
        mcd_reg       <= mcd_next;
        mpl_reg       <= mpl_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        neg_reg       <= neg_next;
        deriv_reg     <= deriv_next;
        dacc_reg      <= dacc_next;
        out_drive_reg <= out_drive_next;
        out_set_reg   <= out_set_next;
    end

    always_comb begin
        logic signed [32:0] diff;
        logic signed [31:0] err_c;
        logic [31:0] err_mag;
        logic [20:0] r21;
        logic        ge;
        logic signed [48:0] inc;
        logic signed [48:0] sum;
        logic signed [48:0] lim;
        logic [52:0] q;
        logic [62:0] p;
        logic signed [31:0] gain;
        logic signed [47:0] opb;
        logic [31:0] gain_mag;
        logic [47:0] opb_mag;
        logic signed [65:0] drv;
        logic [31:0] dmag;
        logic [34:0] msp;
        logic [16:0] t17;
        logic [15:0] tol_new;
        logic        out_free;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        gsel_next      = gsel_reg;
        err_next       = err_reg;
        dt_next        = dt_reg;
        last_err_next  = last_err_reg;
        integ_next     = integ_reg;
        tol_ms_next    = tol_ms_reg;
        acc_next       = acc_reg;
        mcd_next       = mcd_reg;
        mpl_next       = mpl_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        deriv_next     = deriv_reg;
        dacc_next      = dacc_reg;
        out_drive_next = out_drive_reg;
        out_set_next   = out_set_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_free       = !m_valid_reg || m_tready;

        diff = 33'(sp_reg) - 33'(signed'(s_tdata[31:0]));
        if (diff > 33'sd2147483647) begin
            err_c = 32'sh7fffffff;
        end else if (diff < -33'sd2147483648) begin
            err_c = 32'sh80000000;
        end else begin
            err_c = diff[31:0];
        end
        err_mag = err_c[31] ? (~err_c + 32'd1) : err_c;

        r21 = {rem_reg, acc_reg[52]};
        ge  = (r21 >= {1'b0, div_reg});

        q    = acc_reg[52:0];
        p    = acc_reg[78:16];
        inc  = '0;
        sum  = '0;
        lim  = signed'({2'b00, ilim_reg});
        diff = '0;
        gain = '0;
        opb  = '0;
        gain_mag = '0;
        opb_mag  = '0;
        drv  = '0;
        dmag = '0;
        msp  = '0;
        t17  = '0;
        tol_new = '0;

        unique case (state_reg)
            pcs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    err_next   = err_c;
                    dt_next    = s_tdata[51:32];
                    acc_next   = '0;
                    mcd_next   = {60'd0, err_mag};
                    mpl_next   = {28'd0, s_tdata[51:32]};
                    neg_next   = err_c[31];
                    dacc_next  = '0;
                    state_next = pcs_pkg::ST_MUL_I;
                end
            end
            pcs_pkg::ST_MUL_I, pcs_pkg::ST_MUL_R, pcs_pkg::ST_MUL_D,
            pcs_pkg::ST_MUL_G: begin
                if (mpl_reg == '0) begin
                    rem_next = '0;
                    cnt_next = '0;
                    unique case (state_reg)
                        pcs_pkg::ST_MUL_I: begin
                            acc_next   = '0;
                            mcd_next   = {6'd0, acc_reg[91:6]};
                            mpl_next   = pcs_pkg::USEC_RECIP;
                            state_next = pcs_pkg::ST_MUL_R;
                        end
                        pcs_pkg::ST_MUL_R: state_next = pcs_pkg::ST_INT_UPD;
                        pcs_pkg::ST_MUL_D: begin
                            div_next   = dt_reg;
                            state_next = pcs_pkg::ST_DIV_D;
                        end
                        default: state_next = pcs_pkg::ST_GSUM;
                    endcase
                end else begin
                    acc_next = acc_reg + (mpl_reg[0] ? mcd_reg : 92'd0);
                    mcd_next = {mcd_reg[90:0], 1'b0};
                    mpl_next = {1'b0, mpl_reg[47:1]};
                end
            end
            pcs_pkg::ST_DIV_D: begin
                rem_next = ge ? 20'(r21 - {1'b0, div_reg}) : r21[19:0];
                acc_next = {acc_reg[91:53], acc_reg[51:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(pcs_pkg::DIV_STEPS - 1)) begin
                    state_next = pcs_pkg::ST_DERIV;
                end
            end
            pcs_pkg::ST_INT_UPD: begin
                inc = neg_reg ? -signed'({17'd0, acc_reg[90:59]})
                              : signed'({17'd0, acc_reg[90:59]});
                sum = 49'(integ_reg) + inc;
                if (sum > lim) begin
                    sum = lim;
                end
                if (sum < -lim) begin
                    sum = -lim;
                end
                integ_next = sum[47:0];
                diff       = 33'(err_reg) - 33'(last_err_reg);
                acc_next   = '0;
                mcd_next   = {59'd0, (diff[32] ? -diff : diff)};
                mpl_next   = 48'(pcs_pkg::USEC_PER_SEC);
                neg_next   = diff[32];
                gsel_next  = '0;
                if (dt_reg > 20'd1) begin
                    state_next = pcs_pkg::ST_MUL_D;
                end else begin
                    deriv_next = '0;
                    state_next = pcs_pkg::ST_G_LOAD;
                end
            end
            pcs_pkg::ST_DERIV: begin
                if (neg_reg) begin
                    deriv_next = (q > 53'd2147483648) ? 32'sh80000000 : -signed'(q[31:0]);
                end else begin
                    deriv_next = (q > 53'd2147483647) ? 32'sh7fffffff : signed'(q[31:0]);
                end
                state_next = pcs_pkg::ST_G_LOAD;
            end
            pcs_pkg::ST_G_LOAD: begin
                unique case (gsel_reg)
                    2'd0: begin
                        gain = kp_reg;
                        opb  = 48'(err_reg);
                    end
                    2'd1: begin
                        gain = ki_reg;
                        opb  = integ_reg;
                    end
                    default: begin
                        gain = kd_reg;
                        opb  = 48'(deriv_reg);
                    end
                endcase
                gain_mag   = gain[31] ? (~gain + 32'd1) : gain;
                opb_mag    = opb[47] ? (~opb + 48'd1) : opb;
                acc_next   = '0;
                mcd_next   = {60'd0, gain_mag};
                mpl_next   = opb_mag;
                neg_next   = gain[31] ^ opb[47];
                state_next = pcs_pkg::ST_MUL_G;
            end
            pcs_pkg::ST_GSUM: begin
                dacc_next = dacc_reg + (neg_reg ? -signed'({3'd0, p}) : signed'({3'd0, p}));
                if (gsel_reg == 2'd2) begin
                    state_next = pcs_pkg::ST_FINISH;
                end else begin
                    gsel_next  = gsel_reg + 2'd1;
                    state_next = pcs_pkg::ST_G_LOAD;
                end
            end
            pcs_pkg::ST_FINISH: begin
                drv = dacc_reg;
                if (drv < 66'(omin_reg)) begin
                    drv = 66'(omin_reg);
                end
                if (drv > 66'(omax_reg)) begin
                    drv = 66'(omax_reg);
                end
                err_mag = err_reg[31] ? (~err_reg + 32'd1) : err_reg;
                dmag    = deriv_reg[31] ? (~deriv_reg + 32'd1) : deriv_reg;
                msp     = 35'(dt_reg[19:3]) * 35'(pcs_pkg::MSEC_RECIP);
                t17     = {1'b0, tol_ms_reg} + {6'd0, msp[34:24]};
                if ((err_mag < {1'b0, etol_reg}) && (dmag < 32'(pcs_pkg::DERIV_TOLERANCE))) begin
                    tol_new = (t17 > 17'(pcs_pkg::MS_MAX)) ? 16'(pcs_pkg::MS_MAX) : t17[15:0];
                end else begin
                    tol_new = '0;
                end
                if (out_free) begin
                    tol_ms_next    = tol_new;
                    last_err_next  = err_reg;
                    out_drive_next = drv[31:0];
                    out_set_next   = (tol_new >= 16'(pcs_pkg::SETTLE_MSEC));
                    m_valid_next   = 1'b1;
                    state_next     = pcs_pkg::ST_IDLE;
                end
            end
            default: state_next = pcs_pkg::ST_IDLE;
        endcase
    end

    `PCS_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == pcs_pkg::ST_MUL_I)
    `PCS_ASSERT_NEXT(a_stall_holds, (state_reg == pcs_pkg::ST_FINISH) && m_valid_reg && !m_tready, (state_reg == pcs_pkg::ST_FINISH) && m_valid_reg)
    `PCS_ASSERT_IMPL(a_div_count, 1'b1, cnt_reg <= 6'(pcs_pkg::DIV_STEPS))

endmodule
